>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_AT(label, !(cond), msg)

`endif

>>> src/crc8pf_pkg.sv
// ----------------------------------------------------------------------------
// crc8pf_pkg
// types, constants and the crc-8 byte update shared by the packet framer
// ----------------------------------------------------------------------------
package crc8pf_pkg;

  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] CRC_TOPBIT = 8'h80;
  localparam logic [7:0] FRAME_MARK = 8'h7E;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  localparam int MAX_RESULTS = 4;
  localparam int IDX_W       = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic       func;
    logic [4:0] payload_length;
    logic [5:0] sequence_number;
    logic [4:0] frame_type;
    logic [7:0] payload_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_frame;
    logic       protocol_error;
  } rsp_t;

  // results caused by one item, emitted from index 0 up to last_idx
  typedef struct packed {
    logic [IDX_W-1:0]            last_idx;
    rsp_t [MAX_RESULTS-1:0]      items;
  } burst_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOPBIT) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> src/crc8pf_core.sv
// ----------------------------------------------------------------------------
// crc8pf_core
// frame state and crc registers; forms the results of one accepted item
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc8pf_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  crc8pf_pkg::req_t    req,
  output crc8pf_pkg::burst_t  burst
);

  logic [7:0] running_crc;
  logic [7:0] running_crc_next;
  logic [4:0] bytes_remaining;
  logic [4:0] bytes_remaining_next;
  logic       frame_open;
  logic       frame_open_next;

  logic [15:0] hdr;
  logic [7:0]  crc_mark;
  logic [7:0]  crc_hi;
  logic [7:0]  crc_lo;
  logic [7:0]  crc_data;
  logic [4:0]  remaining_dec;

  assign hdr           = {req.payload_length, req.sequence_number, req.frame_type};
  assign crc_mark      = crc8pf_pkg::crc8_feed(8'h00, crc8pf_pkg::FRAME_MARK);
  assign crc_hi        = crc8pf_pkg::crc8_feed(crc_mark, hdr[15:8]);
  assign crc_lo        = crc8pf_pkg::crc8_feed(crc_hi, hdr[7:0]);
  assign crc_data      = crc8pf_pkg::crc8_feed(running_crc, req.payload_byte);
  assign remaining_dec = bytes_remaining - 5'd1;

  always_comb begin
    burst                = '0;
    running_crc_next     = running_crc;
    bytes_remaining_next = bytes_remaining;
    frame_open_next      = frame_open;
    if (req.func == crc8pf_pkg::FUNC_START) begin
      burst.items[0] = '{frame_byte: crc8pf_pkg::FRAME_MARK, last_of_frame: 1'b0,
                         protocol_error: 1'b0};
      burst.items[1] = '{frame_byte: hdr[15:8], last_of_frame: 1'b0, protocol_error: 1'b0};
      burst.items[2] = '{frame_byte: hdr[7:0], last_of_frame: 1'b0, protocol_error: 1'b0};
      burst.items[3] = '{frame_byte: crc_lo, last_of_frame: 1'b1, protocol_error: 1'b0};
      if (req.payload_length == 5'd0) begin
        burst.last_idx       = crc8pf_pkg::IDX_W'(3);
        running_crc_next     = 8'h00;
        bytes_remaining_next = 5'd0;
        frame_open_next      = 1'b0;
      end else begin
        burst.last_idx       = crc8pf_pkg::IDX_W'(2);
        running_crc_next     = crc_lo;
        bytes_remaining_next = req.payload_length;
        frame_open_next      = 1'b1;
      end
    end else if (!frame_open) begin
      burst.items[0] = '{frame_byte: 8'h00, last_of_frame: 1'b1, protocol_error: 1'b1};
      burst.last_idx = '0;
    end else begin
      burst.items[0]       = '{frame_byte: req.payload_byte, last_of_frame: 1'b0,
                               protocol_error: 1'b0};
      burst.items[1]       = '{frame_byte: crc_data, last_of_frame: 1'b1,
                               protocol_error: 1'b0};
      bytes_remaining_next = remaining_dec;
      if (remaining_dec == 5'd0) begin
        burst.last_idx   = crc8pf_pkg::IDX_W'(1);
        running_crc_next = 8'h00;
        frame_open_next  = 1'b0;
      end else begin
        burst.last_idx   = '0;
        running_crc_next = crc_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc     <= 8'h00;
      bytes_remaining <= 5'd0;
      frame_open      <= 1'b0;
    end else if (accept) begin
      running_crc     <= running_crc_next;
      bytes_remaining <= bytes_remaining_next;
      frame_open      <= frame_open_next;
    end
  end

  `ASSERT_AT(a_open_count, frame_open == (bytes_remaining != 5'd0), "open flag and count disagree")
  `ASSERT_AT(a_closed_crc, !frame_open |-> running_crc == 8'h00, "crc not cleared on close")

endmodule

>>> src/crc8pf_emit.sv
// ----------------------------------------------------------------------------
// crc8pf_emit
// result register; holds the results of one item and, while rsp_stall is low, sends one per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc8pf_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  crc8pf_pkg::burst_t burst,
  output logic               free,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output crc8pf_pkg::rsp_t   rsp
);

  logic                                     valid;
  logic [crc8pf_pkg::IDX_W-1:0]             idx;
  logic [crc8pf_pkg::IDX_W-1:0]             last_idx;
  crc8pf_pkg::rsp_t [crc8pf_pkg::MAX_RESULTS-1:0] items;

  assign free      = !valid || (!rsp_stall && idx == last_idx);
  assign rsp_valid = valid;
  assign rsp       = items[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && !rsp_stall) begin
      if (idx == last_idx) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items    <= burst.items;
      last_idx <= burst.last_idx;
    end
  end

  `ASSERT_AT(a_idx_range, valid |-> idx <= last_idx, "result index past last")
  `ASSERT_NEVER(a_load_busy, load && !free, "load while results pending")

endmodule

>>> src/crc8_packet_framer.sv
// ----------------------------------------------------------------------------
// crc8_packet_framer
// packet framer: marker, 16-bit header, payload and crc-8 as a byte stream
// ----------------------------------------------------------------------------
// a start item emits 0x7e and the two header bytes (plus the crc byte when the
// length is zero); a payload item emits its byte, and the last byte of a
// frame also adds the crc byte; a stray payload item gives one error item. the
// result register sends one item per cycle while rsp_stall is low and takes the
// next input in the cycle its last pending item leaves, so payload streams at
// one item per cycle while rsp_stall is low.
module crc8_packet_framer (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  crc8pf_pkg::req_t req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output crc8pf_pkg::rsp_t rsp
);

  logic               accept;
  logic               free;
  crc8pf_pkg::burst_t burst;

  assign req_stall = !free;
  assign accept    = req_valid && free;

  crc8pf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .burst  (burst)
  );

  crc8pf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst     (burst),
    .free      (free),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
